### hdl/ctp_pkg.sv
`default_nettype none

package ctp_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int TICK_W         = 32;

	localparam logic [1:0] CMD_REQ    = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] KIND_GRANT     = 2'd0;
	localparam logic [1:0] KIND_FULL      = 2'd1;
	localparam logic [1:0] KIND_EXPIRED   = 2'd2;
	localparam logic [1:0] KIND_CANCELLED = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

### hdl/ctp_if.sv
`default_nettype none

interface ctp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] timeout_ticks;
	logic        one_shot;
	logic [2:0]  slot_id;

	modport source (output valid, output cmd, output timeout_ticks, output one_shot,
		output slot_id, input ready);
	modport sink (input valid, input cmd, input timeout_ticks, input one_shot,
		input slot_id, output ready);
endinterface

interface ctp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] slot;
	logic       last;

	modport source (output valid, output kind, output slot, output last, input ready);
	modport sink (input valid, input kind, input slot, input last, output ready);
endinterface

`default_nettype wire

### hdl/ctp_ram.sv
`default_nettype none

module ctp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hdl/ctp_alu.sv
`default_nettype none

module ctp_alu (
	input  logic [ctp_pkg::TICK_W-1:0] add_a,
	input  logic [ctp_pkg::TICK_W-1:0] add_b,
	input  logic [ctp_pkg::TICK_W-1:0] sub_a,
	input  logic [ctp_pkg::TICK_W-1:0] sub_b,
	output logic [ctp_pkg::TICK_W-1:0] sum,
	output logic [ctp_pkg::TICK_W-1:0] diff
);

	assign sum  = add_a + add_b;
	assign diff = sub_a - sub_b;

endmodule

`default_nettype wire

### hdl/callback_timer_pool.sv
// Request: one slot of the free search per cycle; the reply waits for the result port.
// Tick: one slot per cycle through the expiry memory read port, stalled while a pending
// expiry waits for the result port.
// Results leave through an output register; one request in flight at a time.
// Reset: tick count zero, every slot free; reload/expiry memories not cleared.
`default_nettype none

module callback_timer_pool #(
	parameter int SLOT_COUNT = ctp_pkg::SLOT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ctp_req_if.sink   req,
	ctp_res_if.source res
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SID_W = ((IDX_W > 3) ? IDX_W : 3) + 1;
	localparam int CNT_W = $clog2(ctp_pkg::MAX_RESULTS + 1);
	localparam int TW    = ctp_pkg::TICK_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [CNT_W-1:0] CAP_M1   = CNT_W'(ctp_pkg::MAX_RESULTS - 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_REQ    = 3'd1;
	localparam logic [2:0] S_CANCEL = 3'd2;
	localparam logic [2:0] S_TSCAN  = 3'd3;
	localparam logic [2:0] S_FLUSH  = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [TW-1:0]         tick_now_q, tick_d;
	logic [SLOT_COUNT-1:0] active_q, active_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  pend_v_q, pend_v_d;
	logic [IDX_W-1:0]      pend_slot_q, pend_slot_d;
	logic [TW-1:0]         timeout_q;
	logic                  one_shot_q;
	logic                  out_v_q;
	ctp_pkg::res_t         out_q;

	logic                  accept, can_load, cur_active, due, adv, cap;
	logic [SID_W-1:0]      sid_ext, idx_ext, pend_ext;
	logic                  sid_ok;
	logic                  load;
	ctp_pkg::res_t         load_res;
	logic                  rel_we, exp_we;
	logic [TW-1:0]         rel_wdata;
	logic [IDX_W-1:0]      rd_addr;
	logic [TW-1:0]         reload_rd, expiry_rd;
	logic [TW-1:0]         add_a, add_b, sum, diff;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign can_load   = !out_v_q || res.ready;
	assign sid_ext    = SID_W'(req.slot_id);
	assign sid_ok     = sid_ext < SID_W'(SLOT_COUNT);
	assign idx_ext    = SID_W'(idx_q);
	assign pend_ext   = SID_W'(pend_slot_q);
	assign cur_active = active_q[idx_q];
	assign due        = cur_active && !diff[TW-1];
	assign cap        = (count_q == CAP_M1);
	assign rel_wdata  = one_shot_q ? '0 : timeout_q;

	always_comb begin
		case (state_q)
			S_REQ: begin
				add_a = tick_now_q;
				add_b = timeout_q;
			end
			S_TSCAN: begin
				add_a = expiry_rd;
				add_b = reload_rd;
			end
			default: begin
				add_a = tick_now_q;
				add_b = TW'(1);
			end
		endcase
	end

	ctp_alu u_alu (
		.add_a (add_a),
		.add_b (add_b),
		.sub_a (tick_now_q),
		.sub_b (expiry_rd),
		.sum   (sum),
		.diff  (diff)
	);

	ctp_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_reload_ram (
		.clk   (clk),
		.we    (rel_we),
		.waddr (idx_q),
		.wdata (rel_wdata),
		.raddr (rd_addr),
		.rdata (reload_rd)
	);

	ctp_ram #(.WIDTH(TW), .DEPTH(SLOT_COUNT), .AW(IDX_W)) u_expiry_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (idx_q),
		.wdata (sum),
		.raddr (rd_addr),
		.rdata (expiry_rd)
	);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		count_d     = count_q;
		pend_v_d    = pend_v_q;
		pend_slot_d = pend_slot_q;
		tick_d      = tick_now_q;
		active_d    = active_q;
		load        = 1'b0;
		load_res    = '0;
		rel_we      = 1'b0;
		exp_we      = 1'b0;
		rd_addr     = idx_q;
		adv         = 1'b0;
		case (state_q)
			S_IDLE: begin
				rd_addr  = '0;
				idx_d    = '0;
				count_d  = '0;
				pend_v_d = 1'b0;
				if (accept) begin
					case (req.cmd)
						ctp_pkg::CMD_REQ: state_d = S_REQ;
						ctp_pkg::CMD_CANCEL: begin
							if (sid_ok) begin
								idx_d   = sid_ext[IDX_W-1:0];
								state_d = S_CANCEL;
							end
						end
						ctp_pkg::CMD_TICK: begin
							tick_d  = sum;
							state_d = S_TSCAN;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_REQ: begin
				if (!cur_active) begin
					if (can_load) begin
						load            = 1'b1;
						load_res.kind   = ctp_pkg::KIND_GRANT;
						load_res.slot   = idx_ext[2:0];
						load_res.last   = 1'b1;
						rel_we          = 1'b1;
						exp_we          = 1'b1;
						active_d[idx_q] = 1'b1;
						state_d         = S_IDLE;
					end
				end else if (idx_q == LAST_IDX) begin
					if (can_load) begin
						load          = 1'b1;
						load_res.kind = ctp_pkg::KIND_FULL;
						load_res.slot = '0;
						load_res.last = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			S_CANCEL: begin
				if (can_load) begin
					load            = 1'b1;
					load_res.kind   = ctp_pkg::KIND_CANCELLED;
					load_res.slot   = idx_ext[2:0];
					load_res.last   = 1'b1;
					active_d[idx_q] = 1'b0;
					state_d         = S_IDLE;
				end
			end
			S_TSCAN: begin
				if (due) begin
					if (!pend_v_q || can_load) begin
						if (pend_v_q) begin
							load          = 1'b1;
							load_res.kind = ctp_pkg::KIND_EXPIRED;
							load_res.slot = pend_ext[2:0];
							load_res.last = 1'b0;
						end
						pend_v_d    = 1'b1;
						pend_slot_d = idx_q;
						count_d     = count_q + CNT_W'(1);
						if (reload_rd != '0) begin
							exp_we = 1'b1;
						end else begin
							active_d[idx_q] = 1'b0;
						end
						adv = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
				if (adv) begin
					if (idx_q == LAST_IDX || (due && cap)) begin
						state_d = S_FLUSH;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						rd_addr = idx_q + IDX_W'(1);
					end
				end
			end
			S_FLUSH: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (can_load) begin
					load          = 1'b1;
					load_res.kind = ctp_pkg::KIND_EXPIRED;
					load_res.slot = pend_ext[2:0];
					load_res.last = 1'b1;
					pend_v_d      = 1'b0;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			tick_now_q <= '0;
			active_q   <= '0;
			count_q    <= '0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			tick_now_q <= tick_d;
			active_q   <= active_d;
			count_q    <= count_d;
			pend_v_q   <= pend_v_d;
			if (load) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_slot_q <= pend_slot_d;
		if (accept) begin
			timeout_q  <= req.timeout_ticks;
			one_shot_q <= req.one_shot;
		end
		if (load) begin
			out_q <= load_res;
		end
	end

	assign res.valid = out_v_q;
	assign res.kind  = out_q.kind;
	assign res.slot  = out_q.slot;
	assign res.last  = out_q.last;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ctp_pkg::MAX_RESULTS))
		else $error("expiry count beyond cap");

	a_pend_counted: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> count_q != '0)
		else $error("pending expiry without count");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.cmd == ctp_pkg::CMD_TICK |=> tick_now_q == $past(tick_now_q) + TW'(1))
		else $error("tick count did not advance by one");

	a_grant_active: assert property (@(posedge clk) disable iff (!arst_n)
		load && load_res.kind == ctp_pkg::KIND_GRANT |=> active_q[$past(idx_q)])
		else $error("granted slot not marked active");

endmodule

`default_nettype wire

### tb/tb_callback_timer_pool.sv
`timescale 1ns / 1ps

module tb_callback_timer_pool;

	localparam int SLOTS        = ctp_pkg::SLOT_COUNT_DEF;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 4 * SLOTS + 20;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ctp_req_if req_ch ();
	ctp_res_if res_ch ();

	callback_timer_pool #(.SLOT_COUNT(SLOTS)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// mirror of the timer pool
	logic [31:0] now_ticks;
	logic        slot_busy   [SLOTS];
	logic [31:0] slot_period [SLOTS];
	logic [31:0] slot_due    [SLOTS];

	ctp_pkg::res_t pending_results[$];

	int errors        = 0;
	int idle_run      = 0;
	int src_idle_pct  = 20;
	int sink_idle_pct = 67;
	int hold_asked    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int n_grant       = 0;
	int n_full        = 0;
	int n_expired     = 0;
	int n_cancel      = 0;
	int busiest_tick  = 0;

	function automatic void pool_step(logic [1:0] cmd, logic [31:0] tmo, logic once,
		logic [2:0] sid);
		ctp_pkg::res_t r;
		ctp_pkg::res_t burst [ctp_pkg::MAX_RESULTS];
		int            fired;
		logic [31:0]   lag;
		bit            found;
		fired = 0;
		found = 1'b0;
		r     = '0;
		case (cmd)
		ctp_pkg::CMD_REQ: begin
			r.kind = ctp_pkg::KIND_FULL;
			r.slot = '0;
			r.last = 1'b1;
			for (int n = 0; n < SLOTS; n++) begin
				if (!found && !slot_busy[n]) begin
					found          = 1'b1;
					slot_busy[n]   = 1'b1;
					slot_period[n] = once ? 32'd0 : tmo;
					slot_due[n]    = now_ticks + tmo;
					r.kind         = ctp_pkg::KIND_GRANT;
					r.slot         = 3'(n);
				end
			end
			if (found)
				n_grant++;
			else
				n_full++;
			pending_results.push_back(r);
		end
		ctp_pkg::CMD_CANCEL: begin
			if (int'(sid) < SLOTS) begin
				slot_busy[sid] = 1'b0;
				r.kind = ctp_pkg::KIND_CANCELLED;
				r.slot = sid;
				r.last = 1'b1;
				pending_results.push_back(r);
				n_cancel++;
			end
		end
		ctp_pkg::CMD_TICK: begin
			now_ticks = now_ticks + 32'd1;
			for (int n = 0; n < SLOTS; n++) begin
				if (fired < ctp_pkg::MAX_RESULTS && slot_busy[n]) begin
					lag = now_ticks - slot_due[n];
					if (!lag[31]) begin
						burst[fired].kind = ctp_pkg::KIND_EXPIRED;
						burst[fired].slot = 3'(n);
						burst[fired].last = 1'b0;
						fired++;
						if (slot_period[n] != 32'd0)
							slot_due[n] = slot_due[n] + slot_period[n];
						else
							slot_busy[n] = 1'b0;
					end
				end
			end
			for (int i = 0; i < fired; i++) begin
				burst[i].last = (i == fired - 1);
				pending_results.push_back(burst[i]);
			end
			n_expired += fired;
			if (fired > busiest_tick)
				busiest_tick = fired;
		end
		default: ;
		endcase
	endfunction

	always @(posedge clk) begin : check_and_predict
		ctp_pkg::res_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result kind=%0d slot=%0d last=%0d", $time,
					res_ch.kind, res_ch.slot, res_ch.last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_ch.kind !== want.kind) begin
					$display("%0t: kind mismatch, expected %0d, got %0d", $time,
						want.kind, res_ch.kind);
					errors++;
				end
				if (res_ch.slot !== want.slot) begin
					$display("%0t: slot mismatch, expected %0d, got %0d", $time,
						want.slot, res_ch.slot);
					errors++;
				end
				if (res_ch.last !== want.last) begin
					$display("%0t: last mismatch, expected %0d, got %0d", $time,
						want.last, res_ch.last);
					errors++;
				end
			end
		end
		if (req_ch.valid && req_ch.ready)
			pool_step(req_ch.cmd, req_ch.timeout_ticks, req_ch.one_shot, req_ch.slot_id);
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= IDLE_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic send_req(logic [1:0] cmd, logic [31:0] tmo, logic once, logic [2:0] sid);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid         <= 1'b0;
			req_ch.cmd           <= 2'($urandom);
			req_ch.timeout_ticks <= $urandom;
			req_ch.one_shot      <= 1'($urandom);
			req_ch.slot_id       <= 3'($urandom);
			@(negedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.cmd           <= cmd;
		req_ch.timeout_ticks <= tmo;
		req_ch.one_shot      <= once;
		req_ch.slot_id       <= sid;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_directed();
		send_req(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 3'd7);
		send_req(ctp_pkg::CMD_TICK, 32'd0, 1'b0, 3'd0);
		send_req(ctp_pkg::CMD_CANCEL, 32'd0, 1'b0, 3'd7);
		// zero periodic, shortest one-shot, wrapped expiries either side of the sign bit
		send_req(ctp_pkg::CMD_REQ, 32'd0, 1'b0, 3'd0);
		send_req(ctp_pkg::CMD_REQ, 32'd1, 1'b1, 3'd0);
		send_req(ctp_pkg::CMD_REQ, 32'hFFFF_FFFF, 1'b0, 3'd0);
		send_req(ctp_pkg::CMD_REQ, 32'h8000_0000, 1'b1, 3'd0);
		send_req(ctp_pkg::CMD_REQ, 32'h7FFF_FFFF, 1'b0, 3'd0);
		repeat (2)
			send_req(ctp_pkg::CMD_TICK, 32'd0, 1'b0, 3'd0);
		for (int s = 2; s <= 4; s++)
			send_req(ctp_pkg::CMD_CANCEL, 32'd0, 1'b0, 3'(s));
		// fill the pool, overflow it, then fire every slot on one tick
		for (int s = 0; s < SLOTS; s++)
			send_req(ctp_pkg::CMD_REQ, 32'd1, 1'(s), 3'd0);
		send_req(ctp_pkg::CMD_REQ, 32'd5, 1'b0, 3'd0);
		send_req(ctp_pkg::CMD_TICK, 32'd0, 1'b0, 3'd0);
		send_req(ctp_pkg::CMD_CANCEL, 32'd0, 1'b0, 3'd0);
	endtask

	task automatic test_random(int count);
		logic [1:0]  cmd;
		logic [31:0] tmo;
		int          pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 35)
				cmd = ctp_pkg::CMD_REQ;
			else if (pick < 55)
				cmd = ctp_pkg::CMD_CANCEL;
			else if (pick < 95)
				cmd = ctp_pkg::CMD_TICK;
			else
				cmd = CMD_UNUSED;
			case ($urandom_range(9))
			0:       tmo = $urandom;
			1:       tmo = 32'hFFFF_FFFF - $urandom_range(6);
			2:       tmo = 32'h7FFF_FFF8 + $urandom_range(15);
			default: tmo = $urandom_range(12);
			endcase
			send_req(cmd, tmo, 1'($urandom), 3'($urandom));
		end
	endtask

	task automatic test_pressure();
		logic [1:0] cmd;
		hold_asked <= hold_asked + 1;
		for (int i = 0; i < 24; i++) begin
			case (i % 4)
			2:       cmd = ctp_pkg::CMD_TICK;
			3:       cmd = ctp_pkg::CMD_CANCEL;
			default: cmd = ctp_pkg::CMD_REQ;
			endcase
			send_req(cmd, 32'(i % 4), 1'(i), 3'(i));
		end
	endtask

	initial begin
		req_ch.valid         = 1'b0;
		req_ch.cmd           = ctp_pkg::CMD_REQ;
		req_ch.timeout_ticks = '0;
		req_ch.one_shot      = 1'b0;
		req_ch.slot_id       = '0;
		res_ch.ready         = 1'b0;
		now_ticks            = '0;
		for (int n = 0; n < SLOTS; n++) begin
			slot_busy[n]   = 1'b0;
			slot_period[n] = '0;
			slot_due[n]    = '0;
		end
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(110);

		src_idle_pct  = 67;
		sink_idle_pct = 20;
		test_random(110);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_pressure();
		test_random(110);

		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("Covered %0d grants, %0d pool-full replies, %0d cancels, %0d expiries",
			n_grant, n_full, n_cancel, n_expired);
		$display("(up to %0d on one tick), under sender and receiver stalls; %0d mismatches.",
			busiest_tick, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
